// File: rtl/core/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the IPv4/TCP segment builder.
// ----------------------------------------------------------------------------
package tsb_pkg;

	localparam int unsigned MAX_PAYLOAD = 1500;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [16:0] MAX_PAYLOAD_W = 17'(MAX_PAYLOAD);

	localparam logic [15:0] IP_VER_TOS   = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO = 16'h4006;
	localparam logic [15:0] TCP_WINDOW   = 16'hFFFF;
	localparam logic [15:0] IP_PROTO_TCP = 16'h0006;
	localparam logic [31:0] OPT_MSS_WORD = 32'h0204FFD7;
	localparam logic [31:0] OPT_WS_WORD  = 32'h01030308;

	localparam logic [19:0] OPT_SUM = 20'(OPT_MSS_WORD[31:16]) + 20'(OPT_MSS_WORD[15:0])
		+ 20'(OPT_WS_WORD[31:16]) + 20'(OPT_WS_WORD[15:0]);

	localparam logic [3:0] HDR_WORDS     = 4'd10;
	localparam logic [3:0] HDR_WORDS_SYN = 4'd12;

	localparam int unsigned SYN_BIT = 1;

	typedef struct packed {
		logic        has_data;
		logic [7:0]  data_byte;
		logic        last;
		logic        ovf;
		logic [7:0]  flags;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] tot_len;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} push_t;

endpackage

// File: rtl/core/tsb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_front
// Accepts words, keeps the payload sum and count, and computes the header
// lengths and checksums in two pipeline stages.
// ----------------------------------------------------------------------------
module tsb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          src_addr,
	input  logic [31:0]          dst_addr,
	input  logic [15:0]          src_port,
	input  logic [15:0]          dest_port,
	input  logic [31:0]          seq_num,
	input  logic [31:0]          ack_num,
	input  logic [7:0]           tcp_flags,
	input  logic [7:0]           data_byte,
	input  logic                 has_data,
	input  logic                 last,
	input  logic                 q_full,
	output tsb_pkg::push_t       push
);
	import tsb_pkg::*;

	logic [15:0] sum_q;
	logic [16:0] cnt_q;
	logic        odd_q;
	logic        ovf_q;

	logic        adv;
	logic        take;
	logic [15:0] term;
	logic [16:0] sum_add;
	logic [15:0] sum_fold;
	logic [15:0] sum_nx;
	logic [16:0] cnt_nx;
	logic        ovf_nx;

	logic        v_s1;
	entry_t      e_s1;
	logic [15:0] sum_s1;
	logic [16:0] cnt_s1;

	logic        v_s2;
	entry_t      e_s2;
	logic [17:0] pa_s2;
	logic [17:0] pb_s2;
	logic [19:0] pc_s2;
	logic [15:0] sum_s2;
	logic [15:0] tcp_len_s2;

	logic        syn_s1;
	logic [16:0] opt_s1;
	logic [17:0] pa;
	logic [17:0] pb;
	logic [19:0] pc;
	logic [7:0]  off_byte;
	entry_t      e_len;

	logic [19:0] ip_raw;
	logic [19:0] tcp_raw;
	logic [16:0] ip_t;
	logic [16:0] tcp_t;
	logic [15:0] ip_f;
	logic [15:0] tcp_f;

	assign adv      = !(v_s2 && q_full);
	assign in_ready = adv;

	always_comb begin
		term     = odd_q ? {8'h00, data_byte} : {data_byte, 8'h00};
		sum_add  = {1'b0, sum_q} + {1'b0, term};
		sum_fold = sum_add[15:0] + {15'd0, sum_add[16]};
		take     = has_data && (cnt_q < MAX_PAYLOAD_W);
		sum_nx   = take ? sum_fold : sum_q;
		cnt_nx   = take ? cnt_q + 17'd1 : cnt_q;
		ovf_nx   = ovf_q || (has_data && !take);
	end

	// running payload state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			odd_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (in_valid && adv) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
				odd_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
				odd_q <= odd_q ^ take;
				ovf_q <= ovf_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: item and updated payload state
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1.has_data  <= has_data;
			e_s1.data_byte <= data_byte;
			e_s1.last      <= last;
			e_s1.ovf       <= ovf_nx;
			e_s1.flags     <= tcp_flags;
			e_s1.saddr     <= src_addr;
			e_s1.daddr     <= dst_addr;
			e_s1.sport     <= src_port;
			e_s1.dport     <= dest_port;
			e_s1.seq       <= seq_num;
			e_s1.ack       <= ack_num;
			e_s1.tot_len   <= '0;
			e_s1.ip_csum   <= '0;
			e_s1.tcp_csum  <= '0;
			sum_s1         <= sum_nx;
			cnt_s1         <= cnt_nx;
		end
	end

	always_comb begin
		syn_s1   = e_s1.flags[SYN_BIT];
		opt_s1   = syn_s1 ? 17'd8 : 17'd0;
		off_byte = syn_s1 ? 8'h70 : 8'h50;
		pa = 18'(e_s1.saddr[31:16]) + 18'(e_s1.saddr[15:0])
			+ 18'(e_s1.daddr[31:16]) + 18'(e_s1.daddr[15:0]);
		pb = 18'(e_s1.sport) + 18'(e_s1.dport)
			+ 18'(e_s1.seq[31:16]) + 18'(e_s1.seq[15:0]);
		pc = 20'(e_s1.ack[31:16]) + 20'(e_s1.ack[15:0]) + 20'({off_byte, e_s1.flags})
			+ 20'(TCP_WINDOW) + 20'(IP_PROTO_TCP) + (syn_s1 ? OPT_SUM : 20'd0);
		e_len         = e_s1;
		e_len.tot_len = 16'(cnt_s1 + opt_s1 + 17'd40);
	end

	// stage 2: partial sums and lengths
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2         <= e_len;
			tcp_len_s2   <= 16'(cnt_s1 + opt_s1 + 17'd20);
			pa_s2        <= pa;
			pb_s2        <= pb;
			pc_s2        <= pc;
			sum_s2       <= sum_s1;
		end
	end

	always_comb begin
		ip_raw  = 20'(pa_s2) + 20'(IP_VER_TOS) + 20'(IP_TTL_PROTO) + 20'(e_s2.tot_len);
		tcp_raw = 20'(pa_s2) + 20'(pb_s2) + pc_s2 + 20'(sum_s2) + 20'(tcp_len_s2);
		ip_t    = {1'b0, ip_raw[15:0]} + {13'd0, ip_raw[19:16]};
		tcp_t   = {1'b0, tcp_raw[15:0]} + {13'd0, tcp_raw[19:16]};
		ip_f    = ip_t[15:0] + {15'd0, ip_t[16]};
		tcp_f   = tcp_t[15:0] + {15'd0, tcp_t[16]};

		push.valid         = v_s2;
		push.data          = e_s2;
		push.data.ip_csum  = ~ip_f;
		push.data.tcp_csum = ~tcp_f;
	end

endmodule

// File: rtl/core/tsb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module tsb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tsb_pkg::push_t  push,
	output logic            full,
	output logic            empty,
	output tsb_pkg::entry_t head,
	input  logic            pop
);
	import tsb_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     cnt_q;
	logic                wr_en;
	logic                rd_en;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = push.valid && !full;
	assign rd_en = pop && !empty;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: rtl/core/tsb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_back
// Emits the payload byte of each queued word and, on a last word, the header
// words or a too-long marker, through an output register.
// ----------------------------------------------------------------------------
module tsb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  tsb_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            part,
	output logic [31:0]     value,
	output logic            frame_end,
	output logic            too_long
);
	import tsb_pkg::*;

	localparam logic [3:0] W_LEN   = 4'd0;
	localparam logic [3:0] W_FRAG  = 4'd1;
	localparam logic [3:0] W_TTL   = 4'd2;
	localparam logic [3:0] W_SADDR = 4'd3;
	localparam logic [3:0] W_DADDR = 4'd4;
	localparam logic [3:0] W_PORTS = 4'd5;
	localparam logic [3:0] W_SEQ   = 4'd6;
	localparam logic [3:0] W_ACK   = 4'd7;
	localparam logic [3:0] W_FLAGS = 4'd8;
	localparam logic [3:0] W_CSUM  = 4'd9;
	localparam logic [3:0] W_MSS   = 4'd10;
	localparam logic [3:0] W_WS    = 4'd11;

	logic        out_valid_q;
	logic        part_q;
	logic [31:0] value_q;
	logic        end_q;
	logic        tl_q;
	logic        pay_done_q;
	logic [3:0]  widx_q;

	logic        load;
	logic        emit;
	logic        emit_pay;
	logic        word_end;
	logic [3:0]  wcnt;
	logic [31:0] word;

	assign load = !out_valid_q || out_ready;

	always_comb begin
		unique case (widx_q)
			W_LEN:   word = {IP_VER_TOS, head.tot_len};
			W_FRAG:  word = 32'd0;
			W_TTL:   word = {IP_TTL_PROTO, head.ip_csum};
			W_SADDR: word = head.saddr;
			W_DADDR: word = head.daddr;
			W_PORTS: word = {head.sport, head.dport};
			W_SEQ:   word = head.seq;
			W_ACK:   word = head.ack;
			W_FLAGS: word = {(head.flags[SYN_BIT] ? 8'h70 : 8'h50), head.flags, TCP_WINDOW};
			W_CSUM:  word = {head.tcp_csum, 16'd0};
			W_MSS:   word = OPT_MSS_WORD;
			W_WS:    word = OPT_WS_WORD;
			default: word = 32'd0;
		endcase
	end

	always_comb begin
		wcnt     = head.flags[SYN_BIT] ? HDR_WORDS_SYN : HDR_WORDS;
		emit_pay = head.has_data && !pay_done_q;
		word_end = head.ovf || (widx_q == wcnt - 4'd1);
		emit     = !empty && load && (emit_pay || head.last);
		if (empty) begin
			pop = 1'b0;
		end else if (!head.has_data && !head.last) begin
			pop = 1'b1;
		end else if (emit_pay) begin
			pop = load && !head.last;
		end else begin
			pop = load && word_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pay_done_q  <= 1'b0;
			widx_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (emit_pay) begin
					pay_done_q <= head.last;
				end else if (word_end) begin
					pay_done_q <= 1'b0;
					widx_q     <= '0;
				end else begin
					widx_q <= widx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (emit_pay) begin
				part_q  <= 1'b0;
				value_q <= {24'd0, head.data_byte};
				end_q   <= 1'b0;
				tl_q    <= 1'b0;
			end else if (head.ovf) begin
				part_q  <= 1'b1;
				value_q <= 32'd0;
				end_q   <= 1'b1;
				tl_q    <= 1'b1;
			end else begin
				part_q  <= 1'b1;
				value_q <= word;
				end_q   <= word_end;
				tl_q    <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign part      = part_q;
	assign value     = value_q;
	assign frame_end = end_q;
	assign too_long  = tl_q;

endmodule

// File: rtl/core/tcp_ipv4_segment_builder.sv
`timescale 1ns / 1ps
// Path: an accepted word is registered in stage 1 and stage 2, queued, then held in the output register.
// Throughput: one word per cycle while the 4-entry queue has room; a last word
// holds the output sequencer while it emits the header words, or the too-long
// marker, after the payload byte if the word carries one.
// The intake stalls only when the queue fills behind the sequencer.
// Reset: arst_n clears the payload sum, count, pipeline, queue and output valid.
// ----------------------------------------------------------------------------
// tcp_ipv4_segment_builder
// Streams payload bytes and appends the IPv4 and TCP headers with checksums.
// ----------------------------------------------------------------------------
module tcp_ipv4_segment_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] seq_num,
	input  logic [31:0] ack_num,
	input  logic [7:0]  tcp_flags,
	input  logic [7:0]  data_byte,
	input  logic        has_data,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        part,
	output logic [31:0] value,
	output logic        frame_end,
	output logic        too_long
);
	import tsb_pkg::*;

	push_t  push;
	entry_t head;
	logic   q_full;
	logic   q_empty;
	logic   pop;

	tsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.src_addr  (src_addr),
		.dst_addr  (dst_addr),
		.src_port  (src_port),
		.dest_port (dest_port),
		.seq_num   (seq_num),
		.ack_num   (ack_num),
		.tcp_flags (tcp_flags),
		.data_byte (data_byte),
		.has_data  (has_data),
		.last      (last),
		.q_full    (q_full),
		.push      (push)
	);

	tsb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop)
	);

	tsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.part      (part),
		.value     (value),
		.frame_end (frame_end),
		.too_long  (too_long)
	);

`ifndef SYNTHESIS
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> part && frame_end && (value == 32'd0))
		else $error("too-long marker malformed");

	a_payload_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !part |-> (value[31:8] == 24'd0) && !frame_end && !too_long)
		else $error("payload result malformed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && q_full |-> !in_ready)
		else $error("intake open while queue full");
`endif

endmodule

// File: verif/segment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_checker
// Watches both channels of the segment builder. For each accepted data word
// it computes the payload echo and, on the last word, the IPv4/TCP header
// words with both checksums or a too-long marker, matched in order to output.
// ----------------------------------------------------------------------------
module segment_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] seq_num,
	input  logic [31:0] ack_num,
	input  logic [7:0]  tcp_flags,
	input  logic [7:0]  data_byte,
	input  logic        has_data,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        part,
	input  logic [31:0] value,
	input  logic        frame_end,
	input  logic        too_long,
	output int          mismatches,
	output int          words_pending,
	output int          words_checked
);

	localparam logic [31:0] MSS_OPTION    = {8'd2, 8'd4, 16'd65495};
	localparam logic [31:0] WSCALE_OPTION = {8'd1, 8'd3, 8'd3, 8'd8};
	localparam logic [7:0]  IP_TTL        = 8'd64;
	localparam logic [7:0]  IP_PROTO      = 8'd6;
	localparam logic [15:0] WINDOW        = 16'hFFFF;

	typedef struct packed {
		logic        part;
		logic [31:0] value;
		logic        frame_end;
		logic        too_long;
	} frame_word_t;

	frame_word_t frame_words_q[$];

	logic [15:0] payload_sum;
	logic [16:0] payload_len;
	logic        odd_byte;
	logic        oversized;

	int fail_count    = 0;
	int checked_count = 0;
	int pending_count = 0;

	assign mismatches    = fail_count;
	assign words_pending = pending_count;
	assign words_checked = checked_count;

	function automatic logic [15:0] oc_add(logic [15:0] acc, logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, acc} + {1'b0, v};
		return t[15:0] + 16'(t[16]);
	endfunction

	function automatic logic [15:0] oc_add32(logic [15:0] acc, logic [31:0] w);
		return oc_add(oc_add(acc, w[31:16]), w[15:0]);
	endfunction

	task automatic predict_frame_words();
		logic [31:0] hw [12];
		logic [15:0] ip_sum;
		logic [15:0] tcp_sum;
		logic [15:0] tcp_len;
		logic [15:0] tot_len;
		logic [16:0] opt_bytes;
		int          n_words;
		if (has_data) begin
			frame_words_q.push_back('{1'b0, {24'h0, data_byte}, 1'b0, 1'b0});
			if (payload_len >= 17'(tsb_pkg::MAX_PAYLOAD)) begin
				oversized = 1'b1;
			end else begin
				payload_sum = oc_add(payload_sum,
					odd_byte ? {8'h00, data_byte} : {data_byte, 8'h00});
				odd_byte    = ~odd_byte;
				payload_len = payload_len + 17'd1;
			end
		end
		if (!last)
			return;
		if (oversized) begin
			frame_words_q.push_back('{1'b1, 32'h0, 1'b1, 1'b1});
		end else begin
			opt_bytes = tcp_flags[1] ? 17'd8 : 17'd0;
			n_words   = tcp_flags[1] ? 12 : 10;
			tcp_len   = 16'(17'd20 + opt_bytes + payload_len);
			tot_len   = 16'(17'd40 + opt_bytes + payload_len);
			hw[0]  = {8'h45, 8'h00, tot_len};
			hw[1]  = 32'h0;
			hw[2]  = {IP_TTL, IP_PROTO, 16'h0};
			hw[3]  = src_addr;
			hw[4]  = dst_addr;
			hw[5]  = {src_port, dest_port};
			hw[6]  = seq_num;
			hw[7]  = ack_num;
			hw[8]  = {4'((17'd20 + opt_bytes) >> 2), 4'h0, tcp_flags, WINDOW};
			hw[9]  = 32'h0;
			hw[10] = MSS_OPTION;
			hw[11] = WSCALE_OPTION;
			ip_sum = 16'h0;
			for (int i = 0; i < 5; i++)
				ip_sum = oc_add32(ip_sum, hw[i]);
			hw[2][15:0] = ~ip_sum;
			tcp_sum = oc_add32(payload_sum, src_addr);
			tcp_sum = oc_add32(tcp_sum, dst_addr);
			tcp_sum = oc_add(tcp_sum, {8'h00, IP_PROTO});
			tcp_sum = oc_add(tcp_sum, tcp_len);
			for (int i = 5; i < n_words; i++)
				tcp_sum = oc_add32(tcp_sum, hw[i]);
			hw[9] = {~tcp_sum, 16'h0};
			for (int i = 0; i < n_words; i++)
				frame_words_q.push_back('{1'b1, hw[i], i == n_words - 1, 1'b0});
		end
		payload_sum = 16'h0;
		payload_len = 17'h0;
		odd_byte    = 1'b0;
		oversized   = 1'b0;
	endtask

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		fail_count++;
	endtask

	task automatic check_result();
		frame_word_t want;
		checked_count++;
		if (frame_words_q.size() == 0) begin
			$display("%0t: result with nothing expected, expected none, actual part=%0b value=%h",
				$time, part, value);
			fail_count++;
			return;
		end
		want = frame_words_q.pop_front();
		if (part !== want.part)
			note_mismatch("part", 32'(want.part), 32'(part));
		if (value !== want.value)
			note_mismatch("value", want.value, value);
		if (frame_end !== want.frame_end)
			note_mismatch("frame_end", 32'(want.frame_end), 32'(frame_end));
		if (too_long !== want.too_long)
			note_mismatch("too_long", 32'(want.too_long), 32'(too_long));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_sum = 16'h0;
			payload_len = 17'h0;
			odd_byte    = 1'b0;
			oversized   = 1'b0;
			frame_words_q.delete();
		end else begin
			if (in_valid && in_ready)
				predict_frame_words();
			if (out_valid && out_ready)
				check_result();
		end
		pending_count = frame_words_q.size();
	end

endmodule

// File: verif/tb_tcp_ipv4_segment_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_ipv4_segment_builder
// Drives directed segments, then random segments under four flow control
// phases; the checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_tcp_ipv4_segment_builder;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 32;
	localparam int PHASE_WORDS  = 100;

	typedef struct {
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [7:0]  data;
		logic        has_data;
		logic        last;
	} seg_word_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [31:0] src_addr   = '0;
	logic [31:0] dst_addr   = '0;
	logic [15:0] src_port   = '0;
	logic [15:0] dest_port  = '0;
	logic [31:0] seq_num    = '0;
	logic [31:0] ack_num    = '0;
	logic [7:0]  tcp_flags  = '0;
	logic [7:0]  data_byte  = '0;
	logic        has_data   = 1'b0;
	logic        last       = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic        part;
	logic [31:0] value;
	logic        frame_end;
	logic        too_long;

	int mismatches;
	int expected_left;
	int results_seen;

	int idle_pct     = 0;
	int stall_pct    = 0;
	int cycles       = 0;
	int words_sent   = 0;
	int segs_sent    = 0;

	int sender_idle [4] = '{0, 61, 0, 23};
	int recv_stall  [4] = '{0, 0, 61, 23};

	tcp_ipv4_segment_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.src_addr  (src_addr),
		.dst_addr  (dst_addr),
		.src_port  (src_port),
		.dest_port (dest_port),
		.seq_num   (seq_num),
		.ack_num   (ack_num),
		.tcp_flags (tcp_flags),
		.data_byte (data_byte),
		.has_data  (has_data),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.part      (part),
		.value     (value),
		.frame_end (frame_end),
		.too_long  (too_long)
	);

	segment_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_addr      (src_addr),
		.dst_addr      (dst_addr),
		.src_port      (src_port),
		.dest_port     (dest_port),
		.seq_num       (seq_num),
		.ack_num       (ack_num),
		.tcp_flags     (tcp_flags),
		.data_byte     (data_byte),
		.has_data      (has_data),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.part          (part),
		.value         (value),
		.frame_end     (frame_end),
		.too_long      (too_long),
		.mismatches    (mismatches),
		.words_pending (expected_left),
		.words_checked (results_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, expected_left);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] pick32();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic seg_word_t rand_header();
		seg_word_t h;
		h.saddr    = pick32();
		h.daddr    = pick32();
		h.sport    = 16'(pick32() >> 16);
		h.dport    = 16'(pick32() >> 16);
		h.seq      = pick32();
		h.ack      = pick32();
		h.flags    = 8'($urandom_range(255));
		h.data     = 8'($urandom_range(255));
		h.has_data = 1'b0;
		h.last     = 1'b0;
		return h;
	endfunction

	function automatic seg_word_t make_word(seg_word_t hdr, logic [7:0] data,
			logic with_data, logic is_last);
		seg_word_t w;
		w          = hdr;
		w.data     = data;
		w.has_data = with_data;
		w.last     = is_last;
		return w;
	endfunction

	task automatic push_word(seg_word_t w);
		if (w.has_data || w.last)
			words_sent++;
		if (w.last)
			segs_sent++;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		src_addr  <= w.saddr;
		dst_addr  <= w.daddr;
		src_port  <= w.sport;
		dest_port <= w.dport;
		seq_num   <= w.seq;
		ack_num   <= w.ack;
		tcp_flags <= w.flags;
		data_byte <= w.data;
		has_data  <= w.has_data;
		last      <= w.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_segment(int n_bytes, bit carry_last, seg_word_t hdr, int noise_pct);
		seg_word_t w;
		bit        final_byte;
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(99) < noise_pct)
				push_word(make_word(rand_header(), 8'($urandom_range(255)), 1'b0, 1'b0));
			final_byte = carry_last && (i == n_bytes - 1);
			w = ($urandom_range(4) == 0 && !final_byte) ? rand_header() : hdr;
			push_word(make_word(w, 8'($urandom_range(255)), 1'b1, final_byte));
		end
		if (!carry_last || n_bytes == 0)
			push_word(make_word(hdr, 8'($urandom_range(255)), 1'b0, 1'b1));
	endtask

	initial begin
		seg_word_t zero_hdr;
		seg_word_t ones_hdr;
		seg_word_t h;
		int        target;
		int        n_bytes;

		zero_hdr = '{default: '0};
		ones_hdr = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, 1'b0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty segments at the field extremes
		push_word(make_word(zero_hdr, 8'h00, 1'b0, 1'b1));
		push_word(make_word(ones_hdr, 8'hFF, 1'b0, 1'b1));

		// IPv4 header sum folds to all ones, checksum sent as zero
		h       = zero_hdr;
		h.daddr = 32'h0000_7AD1;
		h.flags = 8'h10;
		push_word(make_word(h, 8'h00, 1'b0, 1'b1));

		// TCP sum folds to all ones, checksum sent as zero
		push_word(make_word(zero_hdr, 8'hAF, 1'b1, 1'b0));
		push_word(make_word(zero_hdr, 8'hE3, 1'b1, 1'b1));

		// SYN with odd length, an ignored word inside, empty last word
		h       = rand_header();
		h.flags = 8'h02;
		push_word(make_word(h, 8'h00, 1'b1, 1'b0));
		push_word(make_word(rand_header(), 8'h5A, 1'b0, 1'b0));
		push_word(make_word(h, 8'hFF, 1'b1, 1'b0));
		push_word(make_word(h, 8'h80, 1'b1, 1'b0));
		push_word(make_word(h, 8'h00, 1'b0, 1'b1));

		// single byte carried on the last word, all flags set
		push_word(make_word(ones_hdr, 8'h01, 1'b1, 1'b1));

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = sender_idle[phase];
			stall_pct = recv_stall[phase];
			target    = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				n_bytes = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				send_segment(n_bytes, 1'($urandom_range(1)), rand_header(), 10);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d segments, directed checksum corners and random traffic",
			words_sent, segs_sent);
		$display("Checked %0d output words across four flow control phases", results_seen);
		if (mismatches == 0 && expected_left == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
